// ----- rtl/i2cmbe_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types and constants of the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

	localparam int CMD_W    = 3;
	localparam int BYTE_W   = 8;
	localparam int DLY_W    = 10;
	localparam int BIT_W    = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W    = 8;
	localparam int IN_W     = 16;
	localparam int OUT_W    = 16;

	localparam logic [CFG_W-1:0] TICKS_RST   = 8'd1;
	localparam logic [CFG_W-1:0] TIMEOUT_RST = 8'd250;
	localparam logic [BIT_W-1:0] BITS_PER_BYTE = 4'd8;

	localparam logic [CFG_IDX_W-1:0] CFG_TICKS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd1;

	localparam logic [CMD_W-1:0] CMD_START = 3'd1;
	localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_WAIT  = 3'd5;

	typedef enum logic [16:0] {
		PH_IDLE    = 17'h00001,
		PH_ST_A    = 17'h00002,
		PH_ST_B    = 17'h00004,
		PH_SP_A    = 17'h00008,
		PH_SP_B    = 17'h00010,
		PH_SPF_A   = 17'h00020,
		PH_SPF_B   = 17'h00040,
		PH_WA_REL  = 17'h00080,
		PH_WA_CLK  = 17'h00100,
		PH_WA_POLL = 17'h00200,
		PH_WR_DAT  = 17'h00400,
		PH_WR_HI   = 17'h00800,
		PH_WR_LO   = 17'h01000,
		PH_RD_LO   = 17'h02000,
		PH_RD_HI   = 17'h04000,
		PH_AK_LO   = 17'h08000,
		PH_AK_HI   = 17'h10000
	} phase_t;

endpackage

// ----- rtl/i2c_master_bit_engine.sv -----
// Output: the result of an accepted tick transaction is registered and appears in the cycle after it.
// Throughput: one tick transaction per cycle while the output is empty or taken; the sequencer advances once
// per accepted tick and the output register takes the result in the same edge.
// Reset: asynchronous, active low; idle, SCL and SDA high, SDA released,
// ticks_per_us 1, ack_timeout 250, output register empty.
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Tick-driven I2C master: start, stop, byte write/read and ACK polling.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine
	import i2cmbe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,   // cmd[2:0], tx_byte[10:3], send_ack[11], sda_in[12]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,   // scl_out, sda_out, sda_drive, busy_res, done_res,
	                                        // rx_byte[12:5], ack_fail[13]
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [CFG_W-1:0] tpu_q, ato_q;

	phase_t            phase_q, phase_d;
	logic [DLY_W-1:0]  dly_q, dly_d, dly_dec, dly1, dly2, dly4;
	logic [BIT_W-1:0]  bit_q, bit_d, bit_inc;
	logic [BYTE_W-1:0] shf_q, shf_d, poll_q, poll_d, rx_q, rx_d;
	logic              scl_q, scl_d, sda_q, sda_d, drv_q, drv_d;
	logic              fail_q, fail_d, ackc_q, ackc_d, done_d;

	logic [CMD_W-1:0]  in_cmd;
	logic [BYTE_W-1:0] in_tx;
	logic              in_ack, in_sda, s_fire;
	logic [CFG_W-1:0]  tpu_eff;

	assign in_cmd = s_tdata[2:0];
	assign in_tx  = s_tdata[10:3];
	assign in_ack = s_tdata[11];
	assign in_sda = s_tdata[12];

	assign s_tready = !m_tvalid || m_tready;
	assign s_fire   = s_tvalid && s_tready;

	assign tpu_eff = (tpu_q == '0) ? TICKS_RST : tpu_q;
	assign dly1    = {2'b00, tpu_eff};
	assign dly2    = {1'b0, tpu_eff, 1'b0};
	assign dly4    = {tpu_eff, 2'b00};
	assign dly_dec = (dly_q != '0) ? dly_q - 1'b1 : '0;
	assign bit_inc = bit_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q <= TICKS_RST;
			ato_q <= TIMEOUT_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_TICKS:   tpu_q <= cfg_data;
				CFG_TIMEOUT: ato_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d = phase_q;
		dly_d   = dly_q;
		bit_d   = bit_q;
		shf_d   = shf_q;
		poll_d  = poll_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		drv_d   = drv_q;
		rx_d    = rx_q;
		fail_d  = fail_q;
		ackc_d  = ackc_q;
		done_d  = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				bit_d = '0;
				case (in_cmd)
					CMD_START: begin
						drv_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1;
						dly_d = dly4; phase_d = PH_ST_A;
					end
					CMD_STOP: begin
						drv_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
						dly_d = dly4; phase_d = PH_SP_A;
					end
					CMD_WRITE: begin
						drv_d = 1'b1; scl_d = 1'b0;
						sda_d = in_tx[7]; shf_d = {in_tx[6:0], 1'b0};
						dly_d = dly2; phase_d = PH_WR_DAT;
					end
					CMD_READ: begin
						drv_d = 1'b0; scl_d = 1'b0; shf_d = '0; ackc_d = in_ack;
						dly_d = dly2; phase_d = PH_RD_LO;
					end
					CMD_WAIT: begin
						drv_d = 1'b0; sda_d = 1'b1; poll_d = '0;
						dly_d = dly1; phase_d = PH_WA_REL;
					end
					default: ;
				endcase
			end
			PH_WA_POLL: begin
				if (!in_sda) begin
					scl_d = 1'b0; fail_d = 1'b0; phase_d = PH_IDLE; done_d = 1'b1;
				end else if (poll_q >= ato_q) begin
					drv_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
					dly_d = dly4; phase_d = PH_SPF_A;
				end else begin
					poll_d = poll_q + 1'b1;
				end
			end
			default: begin
				dly_d = dly_dec;
				if (dly_dec == '0) begin
					case (phase_q)
						PH_ST_A: begin
							sda_d = 1'b0; dly_d = dly4; phase_d = PH_ST_B;
						end
						PH_ST_B: begin
							scl_d = 1'b0; phase_d = PH_IDLE; done_d = 1'b1;
						end
						PH_SP_A: begin
							scl_d = 1'b1; sda_d = 1'b1; dly_d = dly4; phase_d = PH_SP_B;
						end
						PH_SPF_A: begin
							scl_d = 1'b1; sda_d = 1'b1; dly_d = dly4; phase_d = PH_SPF_B;
						end
						PH_SPF_B: begin
							fail_d = 1'b1; phase_d = PH_IDLE; done_d = 1'b1;
						end
						PH_WA_REL: begin
							scl_d = 1'b1; dly_d = dly1; phase_d = PH_WA_CLK;
						end
						PH_WA_CLK: begin
							if (!in_sda) begin
								scl_d = 1'b0; fail_d = 1'b0;
								phase_d = PH_IDLE; done_d = 1'b1;
							end else if (poll_q >= ato_q) begin
								drv_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
								dly_d = dly4; phase_d = PH_SPF_A;
							end else begin
								poll_d = poll_q + 1'b1; phase_d = PH_WA_POLL;
							end
						end
						PH_WR_DAT: begin
							scl_d = 1'b1; dly_d = dly2; phase_d = PH_WR_HI;
						end
						PH_WR_HI: begin
							scl_d = 1'b0; dly_d = dly2; phase_d = PH_WR_LO;
						end
						PH_WR_LO: begin
							bit_d = bit_inc;
							if (bit_inc >= BITS_PER_BYTE) begin
								phase_d = PH_IDLE; done_d = 1'b1;
							end else begin
								sda_d = shf_q[7]; shf_d = {shf_q[6:0], 1'b0};
								dly_d = dly2; phase_d = PH_WR_DAT;
							end
						end
						PH_RD_LO: begin
							scl_d = 1'b1; shf_d = {shf_q[6:0], in_sda};
							dly_d = dly1; phase_d = PH_RD_HI;
						end
						PH_RD_HI: begin
							bit_d = bit_inc; scl_d = 1'b0; dly_d = dly2;
							if (bit_inc >= BITS_PER_BYTE) begin
								drv_d = 1'b1; sda_d = !ackc_q; phase_d = PH_AK_LO;
							end else begin
								phase_d = PH_RD_LO;
							end
						end
						PH_AK_LO: begin
							scl_d = 1'b1; dly_d = dly2; phase_d = PH_AK_HI;
						end
						PH_AK_HI: begin
							scl_d = 1'b0; rx_d = shf_q; phase_d = PH_IDLE; done_d = 1'b1;
						end
						default: begin
							phase_d = PH_IDLE; done_d = 1'b1;
						end
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			dly_q   <= '0;
			bit_q   <= '0;
			shf_q   <= '0;
			poll_q  <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			drv_q   <= 1'b0;
			rx_q    <= '0;
			fail_q  <= 1'b0;
			ackc_q  <= 1'b0;
		end else if (s_fire) begin
			phase_q <= phase_d;
			dly_q   <= dly_d;
			bit_q   <= bit_d;
			shf_q   <= shf_d;
			poll_q  <= poll_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			drv_q   <= drv_d;
			rx_q    <= rx_d;
			fail_q  <= fail_d;
			ackc_q  <= ackc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s_fire) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			m_tdata <= {2'b00, fail_d, rx_d, done_d, (phase_d != PH_IDLE),
			            drv_d, sda_d, scl_d};
		end
	end

	a_fire_loads: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> m_tvalid)
		else $error("accepted tick produced no result");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[4] && m_tdata[3]))
		else $error("done and busy reported together");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= BITS_PER_BYTE)
		else $error("bit counter out of range");

	a_read_released: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RD_LO || phase_q == PH_RD_HI) |-> !drv_q)
		else $error("SDA driven during read data bits");

endmodule
